@@ rtl/core/daily_schedule_interpolator_macros.svh @@
// ----------------------------------------------------------------------------
// Daily schedule interpolator assertion macros
// Shared concurrent assertion wrappers for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef DAILY_SCHEDULE_INTERPOLATOR_MACROS_SVH
`define DAILY_SCHEDULE_INTERPOLATOR_MACROS_SVH

// Checked on every clock edge outside of reset.
`define DSI_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every clock edge, reset included.
`define DSI_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/dsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Daily schedule interpolator package
// Sizes, constants, command codes and memory request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsi_pkg;

  // Table geometry.
  localparam int CHANNELS = 8;
  localparam int SLOTS    = 48;
  localparam int LV_DEPTH = CHANNELS * SLOTS;
  localparam int LV_AW    = $clog2(LV_DEPTH);
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int LEVEL_W = 7;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Time arithmetic.
  localparam int SECS_W       = 17;
  localparam int T_W          = 11;
  localparam int SLOT_SECONDS = 1800;
  localparam int DAY_SECONDS  = 86400;
  localparam int MAX_LEVEL    = 100;

  // Division by 1800 as (x >> 3) / 225, done as a multiply by a reciprocal.
  localparam int RECIP_MUL   = 9321;
  localparam int RECIP_SHIFT = 21;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_FORGET = 2'd2
  } cmd_e;

  // Level table request: one write port and two read ports.
  typedef struct packed {
    logic               we;
    logic [LV_AW-1:0]   waddr;
    logic [LEVEL_W-1:0] wdata;
    logic [LV_AW-1:0]   raddr_a;
    logic [LV_AW-1:0]   raddr_b;
  } lv_req_t;

  // Last reported level request.
  typedef struct packed {
    logic               we;
    logic               forget;
    logic [CH_AW-1:0]   waddr;
    logic [LEVEL_W-1:0] wdata;
    logic [CH_AW-1:0]   raddr;
  } last_req_t;

  // Map the channel field onto a table row index.
  function automatic logic [CH_AW-1:0] ch_index(input logic [CHAN_W-1:0] ch);
    logic [CH_AW+CHAN_W-1:0] wide;
    wide = {{CH_AW{1'b0}}, ch};
    return wide[CH_AW-1:0];
  endfunction

  // Flat address of one slot of one channel.
  function automatic logic [LV_AW-1:0] lv_addr(input logic [CH_AW-1:0]  ch,
                                               input logic [SLOT_W-1:0] slot);
    return LV_AW'(ch) * LV_AW'(SLOTS) + LV_AW'(slot);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/daily_schedule_interpolator.sv @@
// ----------------------------------------------------------------------------
// Daily schedule interpolator
// Per-channel half-hour power schedule with linear interpolation between
// slots and change detection against the last reported power.
// ----------------------------------------------------------------------------
// The block takes one word at a time. An evaluate word steps the sequencer
// through time conversion, slot division, the table read, the multiply,
// the floor division and the final add before its result is loaded into
// the output register; a write, forget or unused word goes from time
// conversion straight to that load. The next word is accepted the cycle
// after the load, even while the previous result still waits to be taken;
// the load itself waits while an older result is held by out_stall_i.
// After reset the level table is zero-filled one entry per cycle;
// input stays stalled meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "daily_schedule_interpolator_macros.svh"

module daily_schedule_interpolator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [dsi_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [dsi_pkg::CHAN_W-1:0]   channel_i,
  input  wire logic [dsi_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [dsi_pkg::LEVEL_W-1:0]  level_i,
  input  wire logic [dsi_pkg::HOUR_W-1:0]   hour_i,
  input  wire logic [dsi_pkg::MIN_W-1:0]    minute_i,
  input  wire logic [dsi_pkg::SEC_W-1:0]    second_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [dsi_pkg::LEVEL_W-1:0]       power_o,
  output logic                              changed_o
);

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TIME = 4'd1;
  localparam logic [3:0] ST_SLOT = 4'd2;
  localparam logic [3:0] ST_READ = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_NORM = 4'd5;
  localparam logic [3:0] ST_QUOT = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam int PROD_W = 20;
  localparam int NUM_W  = 18;

  logic [3:0] state_q, state_d;

  // Captured word.
  logic [dsi_pkg::CMD_W-1:0]   cmd_q;
  logic [dsi_pkg::CHAN_W-1:0]  channel_q;
  logic [dsi_pkg::SLOT_W-1:0]  slot_q;
  logic [dsi_pkg::LEVEL_W-1:0] level_q;
  logic [dsi_pkg::HOUR_W-1:0]  hour_q;
  logic [dsi_pkg::MIN_W-1:0]   minute_q;
  logic [dsi_pkg::SEC_W-1:0]   second_q;

  // Datapath registers.
  logic [dsi_pkg::SECS_W-1:0]  secs_q;
  logic [dsi_pkg::SLOT_W-1:0]  i1_q;
  logic [dsi_pkg::T_W-1:0]     t_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic [dsi_pkg::LEVEL_W-1:0] p1_q;
  logic [dsi_pkg::LEVEL_W-1:0] last_val_q;
  logic                        last_vld_q;
  logic                        neg_q;
  logic [NUM_W-1:0]            num_q;
  logic [dsi_pkg::LEVEL_W-1:0] quot_q;
  logic [dsi_pkg::LEVEL_W-1:0] res_power_q;
  logic                        res_changed_q;

  // Output register.
  logic                        out_valid_q;
  logic [dsi_pkg::LEVEL_W-1:0] out_power_q;
  logic                        out_changed_q;

  logic                        in_accept;
  logic                        out_load;
  logic                        ch_ok;
  logic [dsi_pkg::CH_AW-1:0]   ch_idx;
  logic [dsi_pkg::LEVEL_W-1:0] level_sat;
  logic [dsi_pkg::SECS_W-1:0]  secs_raw;
  logic [27:0]                 i1_prod;
  logic [dsi_pkg::SLOT_W-1:0]  i2;
  logic signed [PROD_W-1:0]    diff_ext;
  logic signed [PROD_W-1:0]    t_ext;
  logic [29:0]                 quot_prod;
  logic [dsi_pkg::LEVEL_W-1:0] fin_power;
  logic                        fin_changed;

  dsi_pkg::lv_req_t            lv_req;
  dsi_pkg::last_req_t          last_req;
  logic [dsi_pkg::LEVEL_W-1:0] lv_rdata_a;
  logic [dsi_pkg::LEVEL_W-1:0] lv_rdata_b;
  logic                        lv_clear_busy;
  logic [dsi_pkg::LEVEL_W-1:0] last_rdata;
  logic                        last_rvalid;

  dsi_level_mem u_level_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (lv_req),
    .rdata_a_o    (lv_rdata_a),
    .rdata_b_o    (lv_rdata_b),
    .clear_busy_o (lv_clear_busy)
  );

  dsi_last_mem u_last_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (last_req),
    .rdata_o  (last_rdata),
    .rvalid_o (last_rvalid)
  );

  // Handshakes.
  assign in_stall_o = (state_q != ST_IDLE) || lv_clear_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Channel decode and write level saturation.
  assign ch_ok     = (32'(channel_q) < dsi_pkg::CHANNELS);
  assign ch_idx    = dsi_pkg::ch_index(channel_q);
  assign level_sat = (level_q > dsi_pkg::LEVEL_W'(dsi_pkg::MAX_LEVEL)) ?
                     dsi_pkg::LEVEL_W'(dsi_pkg::MAX_LEVEL) : level_q;

  // Seconds of the day, wrapped once past midnight.
  assign secs_raw = dsi_pkg::SECS_W'(hour_q) * dsi_pkg::SECS_W'(3600) +
                    dsi_pkg::SECS_W'(minute_q) * dsi_pkg::SECS_W'(60) +
                    dsi_pkg::SECS_W'(second_q);

  // Slot index by reciprocal multiply, next slot wraps to zero.
  assign i1_prod = 28'(secs_q[dsi_pkg::SECS_W-1:3]) * 28'(dsi_pkg::RECIP_MUL);
  assign i2      = (i1_q == dsi_pkg::SLOT_W'(dsi_pkg::SLOTS - 1)) ? '0 : i1_q + 1'b1;

  // Signed level difference and offset within the slot.
  assign diff_ext = PROD_W'($signed({1'b0, lv_rdata_b})) -
                    PROD_W'($signed({1'b0, lv_rdata_a}));
  assign t_ext    = PROD_W'($signed({1'b0, t_q}));

  // Quotient of the magnitude by the slot length.
  assign quot_prod = 30'(num_q[NUM_W-1:3]) * 30'(dsi_pkg::RECIP_MUL);

  // Final power and change flag.
  assign fin_power   = neg_q ? (p1_q - quot_q) : (p1_q + quot_q);
  assign fin_changed = !last_vld_q || (last_val_q != fin_power);

  // Memory requests.
  always_comb begin
    lv_req         = '0;
    lv_req.waddr   = dsi_pkg::lv_addr(ch_idx, slot_q);
    lv_req.wdata   = level_sat;
    lv_req.raddr_a = dsi_pkg::lv_addr(ch_idx, i1_q);
    lv_req.raddr_b = dsi_pkg::lv_addr(ch_idx, i2);
    lv_req.we      = (state_q == ST_TIME) && ch_ok &&
                     (cmd_q == dsi_pkg::CMD_WRITE) &&
                     (slot_q < dsi_pkg::SLOT_W'(dsi_pkg::SLOTS));

    last_req        = '0;
    last_req.waddr  = ch_idx;
    last_req.raddr  = ch_idx;
    last_req.wdata  = fin_power;
    last_req.we     = (state_q == ST_FIN);
    last_req.forget = (state_q == ST_TIME) && ch_ok && (cmd_q == dsi_pkg::CMD_FORGET);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_TIME;
      end
      ST_TIME: begin
        if (ch_ok && (cmd_q == dsi_pkg::CMD_EVAL)) state_d = ST_SLOT;
        else state_d = ST_OUT;
      end
      ST_SLOT: state_d = ST_READ;
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_NORM;
      ST_NORM: state_d = ST_QUOT;
      ST_QUOT: state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, each loaded in its own step.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= cmd_i;
      channel_q <= channel_i;
      slot_q    <= slot_i;
      level_q   <= level_i;
      hour_q    <= hour_i;
      minute_q  <= minute_i;
      second_q  <= second_i;
    end
    unique case (state_q)
      ST_TIME: begin
        secs_q <= (secs_raw >= dsi_pkg::SECS_W'(dsi_pkg::DAY_SECONDS)) ?
                  secs_raw - dsi_pkg::SECS_W'(dsi_pkg::DAY_SECONDS) : secs_raw;
        res_power_q   <= '0;
        res_changed_q <= 1'b0;
      end
      ST_SLOT: begin
        i1_q <= dsi_pkg::SLOT_W'(i1_prod >> dsi_pkg::RECIP_SHIFT);
      end
      ST_READ: begin
        t_q <= dsi_pkg::T_W'(secs_q - dsi_pkg::SECS_W'(i1_q) *
                                      dsi_pkg::SECS_W'(dsi_pkg::SLOT_SECONDS));
      end
      ST_MUL: begin
        prod_q     <= diff_ext * t_ext;
        p1_q       <= lv_rdata_a;
        last_val_q <= last_rdata;
        last_vld_q <= last_rvalid;
      end
      ST_NORM: begin
        // Floor of a negative quotient is minus the ceiling of its magnitude.
        neg_q <= prod_q[PROD_W-1];
        num_q <= prod_q[PROD_W-1] ?
                 NUM_W'(-prod_q + PROD_W'(dsi_pkg::SLOT_SECONDS - 1)) : NUM_W'(prod_q);
      end
      ST_QUOT: begin
        quot_q <= dsi_pkg::LEVEL_W'(quot_prod >> dsi_pkg::RECIP_SHIFT);
      end
      ST_FIN: begin
        res_power_q   <= fin_power;
        res_changed_q <= fin_changed;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_power_q   <= res_power_q;
      out_changed_q <= res_changed_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = out_power_q;
  assign changed_o   = out_changed_q;

  // Assertions.
  `DSI_ASSERT_ALWAYS(a_clear_stalls, clk_i, lv_clear_busy |-> in_stall_o)
  `DSI_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_accept |=> state_q != ST_IDLE)
  `DSI_ASSERT(a_done_loads_output, clk_i, rst_ni,
    (state_q == ST_OUT && state_d == ST_IDLE) |=> out_valid_o)
  `DSI_ASSERT(a_no_write_in_clear, clk_i, rst_ni, lv_req.we |-> !lv_clear_busy)
  `DSI_ASSERT(a_quot_in_range, clk_i, rst_ni,
    (state_q == ST_FIN) |-> quot_q <= dsi_pkg::LEVEL_W'(dsi_pkg::MAX_LEVEL))

endmodule

`default_nettype wire

@@ rtl/core/dsi_level_mem.sv @@
// ----------------------------------------------------------------------------
// Slot level table
// Level memory for all channels, one write and two registered read ports,
// with a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsi_level_mem (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dsi_pkg::lv_req_t                req_i,
  output logic [dsi_pkg::LEVEL_W-1:0]          rdata_a_o,
  output logic [dsi_pkg::LEVEL_W-1:0]          rdata_b_o,
  output logic                                 clear_busy_o
);

  logic [dsi_pkg::LEVEL_W-1:0] mem [dsi_pkg::LV_DEPTH];
  logic [dsi_pkg::LEVEL_W-1:0] rdata_a_q;
  logic [dsi_pkg::LEVEL_W-1:0] rdata_b_q;
  logic [dsi_pkg::LV_AW-1:0]   clr_cnt_q;
  logic                        clr_busy_q;
  logic                        we;
  logic [dsi_pkg::LV_AW-1:0]   waddr;
  logic [dsi_pkg::LEVEL_W-1:0] wdata;

  // Clearing sweep writes zero to one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == dsi_pkg::LV_AW'(dsi_pkg::LV_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // The sweep owns the write port while it runs.
  assign we    = clr_busy_q | req_i.we;
  assign waddr = clr_busy_q ? clr_cnt_q : req_i.waddr;
  assign wdata = clr_busy_q ? '0 : req_i.wdata;

  // Storage with registered reads.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_q <= mem[req_i.raddr_a];
    rdata_b_q <= mem[req_i.raddr_b];
  end

  assign rdata_a_o    = rdata_a_q;
  assign rdata_b_o    = rdata_b_q;
  assign clear_busy_o = clr_busy_q;

endmodule

`default_nettype wire

@@ rtl/core/dsi_last_mem.sv @@
// ----------------------------------------------------------------------------
// Last reported level store
// Per-channel memory of the last reported power with a valid bit each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsi_last_mem (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dsi_pkg::last_req_t        req_i,
  output logic [dsi_pkg::LEVEL_W-1:0]    rdata_o,
  output logic                           rvalid_o
);

  logic [dsi_pkg::LEVEL_W-1:0]  mem [dsi_pkg::CHANNELS];
  logic [dsi_pkg::CHANNELS-1:0] valid_q;
  logic [dsi_pkg::LEVEL_W-1:0]  rdata_q;
  logic                         rvalid_q;

  // Valid bits: set by a report, cleared by a forget or by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end else if (req_i.forget) begin
      valid_q[req_i.waddr] <= 1'b0;
    end
  end

  // Value storage with a registered read of value and valid bit.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q  <= mem[req_i.raddr];
    rvalid_q <= valid_q[req_i.raddr];
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire
